// ----- rtl/rbsi_pkg.sv -----
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int CORDIC_ITERS = 24;
  localparam int CORDIC_K     = 652032874;
  // angle reduce + iterations + quadrant map
  localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
  localparam int CS_W         = 32;

  localparam int ROT_LAT  = 3;
  localparam int QUOT_BITS = 17;
  localparam int DIV_LAT  = QUOT_BITS + 2;

  localparam int BOX_W    = 31;
  localparam int FRAC_W   = 17;
  localparam int T_W      = 19;
  localparam int NORM_W   = 16;
  localparam int ONE_Q16  = 65536;
  localparam int T_SAT    = 131072;
  localparam int Q14_ONE  = 16384;
  localparam longint ROUND30 = 64'sd536870912;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    FACE_NONE,
    FACE_NEG_X,
    FACE_POS_X,
    FACE_NEG_Y,
    FACE_POS_Y
  } face_t;

  // atan(2^-i) in 2^32 per turn
  function automatic logic [31:0] atan_val(input int unsigned i);
    case (i)
      0:  atan_val = 32'h20000000;
      1:  atan_val = 32'h12E4051E;
      2:  atan_val = 32'h09FB385B;
      3:  atan_val = 32'h051111D4;
      4:  atan_val = 32'h028B0D43;
      5:  atan_val = 32'h0145D7E1;
      6:  atan_val = 32'h00A2F61E;
      7:  atan_val = 32'h00517C55;
      8:  atan_val = 32'h0028BE53;
      9:  atan_val = 32'h00145F2F;
      10: atan_val = 32'h000A2F98;
      11: atan_val = 32'h000517CC;
      12: atan_val = 32'h00028BE6;
      13: atan_val = 32'h000145F3;
      14: atan_val = 32'h0000A2F9;
      15: atan_val = 32'h0000517D;
      16: atan_val = 32'h000028BE;
      17: atan_val = 32'h0000145F;
      18: atan_val = 32'h00000A30;
      19: atan_val = 32'h00000518;
      20: atan_val = 32'h0000028C;
      21: atan_val = 32'h00000146;
      22: atan_val = 32'h000000A3;
      23: atan_val = 32'h00000051;
      default: atan_val = 32'h0;
    endcase
  endfunction

  // Q2.30 -> Q1.14, round half up, clamp to +-1.0
  function automatic logic signed [NORM_W-1:0] to_q14(input logic signed [CS_W-1:0] v);
    logic signed [CS_W:0] sum;
    logic signed [CS_W-16:0] r;
    sum = (CS_W+1)'(v) + (CS_W+1)'(32768);
    r = (CS_W-15)'(sum >>> 16);
    if (r > (CS_W-15)'(Q14_ONE)) begin
      to_q14 = NORM_W'(Q14_ONE);
    end else if (r < -(CS_W-15)'(Q14_ONE)) begin
      to_q14 = -NORM_W'(Q14_ONE);
    end else begin
      to_q14 = NORM_W'(r);
    end
  endfunction

endpackage

// ----- rtl/ray_box_slab_intersection_core.sv -----
`timescale 1ns / 1ps
// Channel  Handshake          Payload
// input    start, busy        in_ray_start_x/y, in_ray_end_x/y, in_max_fraction,
//                             in_body_x/y, in_body_angle
// result   out_valid (strobe) out_hit, out_fraction, out_normal_x, out_normal_y
// config   cfg_we             cfg_index, cfg_data
//
// One beat accepted per clock; busy is never raised, the pipeline always advances.
// Stages in order: CORDIC, rotation multipliers, slab setup,
// 17-bit restoring divider, slab combine.
// rst_n (sync) clears the valid bits in flight and loads box size 1.0 x 1.0.
// The receiver cannot stall: each result shows for exactly one cycle.
module ray_box_slab_intersection_core import rbsi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_ray_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_ray_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_ray_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_ray_end_y,
  input  logic [FRAC_W-1:0]             in_max_fraction,
  input  logic signed [COORD_WIDTH-1:0] in_body_x,
  input  logic signed [COORD_WIDTH-1:0] in_body_y,
  input  logic [ANGLE_WIDTH-1:0]        in_body_angle,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [BOX_W-1:0]              cfg_data,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [FRAC_W-1:0]             out_fraction,
  output logic signed [NORM_W-1:0]      out_normal_x,
  output logic signed [NORM_W-1:0]      out_normal_y
);

  localparam int DW  = COORD_WIDTH + 1;          // world deltas
  localparam int LW  = DW + 3;                   // local coords
  localparam int NW  = ((LW > 31) ? LW : 31) + 3; // slab numerator / denominator
  localparam int W1  = 1 + FRAC_W + 4 * DW;
  localparam int W2  = 1 + FRAC_W + 2 * NORM_W;
  localparam int W3  = W2 + 4;

  // ---- config registers ----
  logic [BOX_W-1:0] box_width_r, box_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= BOX_W'(ONE_Q16);
      box_height_r <= BOX_W'(ONE_Q16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_WIDTH:  box_width_r  <= cfg_data;
        REG_BOX_HEIGHT: box_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---- intake: deltas to box center, clamp max fraction ----
  logic                 acc;
  logic [FRAC_W-1:0]    mf_in;
  logic signed [DW-1:0] ax_in, ay_in, bx_in, by_in;

  assign acc   = start && !busy;
  assign mf_in = (in_max_fraction > FRAC_W'(ONE_Q16)) ? FRAC_W'(ONE_Q16) : in_max_fraction;
  assign ax_in = DW'(in_ray_start_x) - DW'(in_body_x);
  assign ay_in = DW'(in_ray_start_y) - DW'(in_body_y);
  assign bx_in = DW'(in_ray_end_x) - DW'(in_body_x);
  assign by_in = DW'(in_ray_end_y) - DW'(in_body_y);

  // deltas wait alongside the CORDIC
  logic [W1-1:0] l1_out;
  logic          v1;
  logic [FRAC_W-1:0] mf1;
  logic signed [DW-1:0] ax1, ay1, bx1, by1;

  rbsi_dly #(.W(W1), .DEPTH(CORDIC_LAT)) u_dly_delta (
    .clk  (clk),
    .rst_n(rst_n),
    .din  ({acc, mf_in, ax_in, ay_in, bx_in, by_in}),
    .dout (l1_out)
  );

  assign {v1, mf1, ax1, ay1, bx1, by1} = l1_out;

  logic signed [CS_W-1:0] cos_w, sin_w;

  rbsi_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
    .clk  (clk),
    .angle(in_body_angle),
    .cos_o(cos_w),
    .sin_o(sin_w)
  );

  // ---- rotate into box frame ----
  logic signed [LW-1:0] l1x, l1y, l2x, l2y;

  rbsi_rotate #(.DW(DW)) u_rotate (
    .clk(clk),
    .ax (ax1),
    .ay (ay1),
    .bx (bx1),
    .by (by1),
    .c  (cos_w),
    .s  (sin_w),
    .l1x(l1x),
    .l1y(l1y),
    .l2x(l2x),
    .l2y(l2y)
  );

  // face normal in Q1.14 rides beside the multipliers
  logic [W2-1:0] l2_out;
  logic          v2;
  logic [FRAC_W-1:0] mf2;
  logic signed [NORM_W-1:0] c14_2, s14_2;

  rbsi_dly #(.W(W2), .DEPTH(ROT_LAT)) u_dly_rot (
    .clk  (clk),
    .rst_n(rst_n),
    .din  ({v1, mf1, to_q14(cos_w), to_q14(sin_w)}),
    .dout (l2_out)
  );

  assign {v2, mf2, c14_2, s14_2} = l2_out;

  // ---- slab setup: t = (-/+size - 2p) / (2d) ----
  logic signed [LW:0]   dx_c, dy_c, p2x_c, p2y_c;
  logic signed [NW-1:0] szx_c, szy_c, px_c, py_c;
  logic signed [NW-1:0] nx1_r, nx2_r, dnx_r, ny1_r, ny2_r, dny_r;
  logic                 zx_r, zy_r, rx_r, ry_r;
  logic [W2-1:0]        side_r;

  always_comb begin
    dx_c  = (LW+1)'(l2x) - (LW+1)'(l1x);
    dy_c  = (LW+1)'(l2y) - (LW+1)'(l1y);
    p2x_c = {l1x, 1'b0};
    p2y_c = {l1y, 1'b0};
    szx_c = NW'($signed({1'b0, box_width_r}));
    szy_c = NW'($signed({1'b0, box_height_r}));
    px_c  = NW'(p2x_c);
    py_c  = NW'(p2y_c);
  end

  always_ff @(posedge clk) begin
    nx1_r <= -szx_c - px_c;
    nx2_r <= szx_c - px_c;
    dnx_r <= NW'($signed({dx_c, 1'b0}));
    ny1_r <= -szy_c - py_c;
    ny2_r <= szy_c - py_c;
    dny_r <= NW'($signed({dy_c, 1'b0}));
    // zero direction: axis only tests the start point against the slab
    zx_r  <= dx_c == '0;
    zy_r  <= dy_c == '0;
    rx_r  <= (px_c < -szx_c) || (px_c > szx_c);
    ry_r  <= (py_c < -szy_c) || (py_c > szy_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r <= {v2, mf2, c14_2, s14_2};
    end
  end

  logic signed [T_W-1:0] tx1, tx2, ty1, ty2;

  rbsi_div #(.NW(NW)) u_div_x1 (.clk(clk), .num(nx1_r), .den(dnx_r), .quot(tx1));
  rbsi_div #(.NW(NW)) u_div_x2 (.clk(clk), .num(nx2_r), .den(dnx_r), .quot(tx2));
  rbsi_div #(.NW(NW)) u_div_y1 (.clk(clk), .num(ny1_r), .den(dny_r), .quot(ty1));
  rbsi_div #(.NW(NW)) u_div_y2 (.clk(clk), .num(ny2_r), .den(dny_r), .quot(ty2));

  logic [W3-1:0] l3_out;
  logic          v3, zx3, zy3, rx3, ry3;
  logic [FRAC_W-1:0] mf3;
  logic signed [NORM_W-1:0] c14_3, s14_3;

  rbsi_dly #(.W(W3), .DEPTH(DIV_LAT)) u_dly_div (
    .clk  (clk),
    .rst_n(rst_n),
    .din  ({side_r, zx_r, zy_r, rx_r, ry_r}),
    .dout (l3_out)
  );

  assign {v3, mf3, c14_3, s14_3, zx3, zy3, rx3, ry3} = l3_out;

  // ---- slab combine: entry max, exit min ----
  logic signed [T_W-1:0]    xlo, xhi, ylo, yhi, tmin, tmax;
  face_t                    fxlo, fxhi, fylo, fyhi, face;
  logic                     ok, hit_c;
  logic signed [NORM_W-1:0] nx_c, ny_c;

  always_comb begin
    xlo = tx1; xhi = tx2; fxlo = FACE_NEG_X; fxhi = FACE_POS_X;
    if (tx1 > tx2) begin
      xlo = tx2; xhi = tx1; fxlo = FACE_POS_X; fxhi = FACE_NEG_X;
    end
    ylo = ty1; yhi = ty2; fylo = FACE_NEG_Y; fyhi = FACE_POS_Y;
    if (ty1 > ty2) begin
      ylo = ty2; yhi = ty1; fylo = FACE_POS_Y; fyhi = FACE_NEG_Y;
    end
    tmin = -T_W'(ONE_Q16);
    tmax = T_W'(mf3);
    face = FACE_NONE;
    ok   = 1'b1;
    if (zx3) begin
      ok = !rx3;
    end else begin
      if (xlo > tmin) begin
        tmin = xlo;
        face = fxlo;
      end
      if (xhi < tmax) tmax = xhi;
    end
    // a rejected X axis already forces a miss
    if (zy3) begin
      ok = ok && !ry3;
    end else begin
      if (ylo > tmin) begin
        tmin = ylo;
        face = fylo;
      end
      if (yhi < tmax) tmax = yhi;
    end
    hit_c = ok && !tmin[T_W-1] && (tmin <= tmax);
    case (face)
      FACE_NEG_X: begin nx_c = -c14_3; ny_c = -s14_3; end
      FACE_POS_X: begin nx_c = c14_3;  ny_c = s14_3;  end
      FACE_NEG_Y: begin nx_c = s14_3;  ny_c = -c14_3; end
      FACE_POS_Y: begin nx_c = -s14_3; ny_c = c14_3;  end
      default:    begin nx_c = '0;     ny_c = '0;     end
    endcase
  end

  logic                     out_valid_r, hit_r;
  logic [FRAC_W-1:0]        frac_r;
  logic signed [NORM_W-1:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3;
    end
    hit_r  <= hit_c;
    frac_r <= hit_c ? tmin[FRAC_W-1:0] : '0;
    nx_r   <= hit_c ? nx_c : '0;
    ny_r   <= hit_c ? ny_c : '0;
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_fraction = frac_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;

endmodule

// ----- rtl/rbsi_dly.sv -----
`timescale 1ns / 1ps
module rbsi_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sr_r[i] <= '0;
    end else begin
      sr_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign dout = sr_r[DEPTH-1];

endmodule

// ----- rtl/rbsi_cordic.sv -----
`timescale 1ns / 1ps
module rbsi_cordic import rbsi_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  localparam int XW = 34;
  localparam int ZW = 33;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  logic [31:0]          a32;
  logic signed [XW-1:0] x_r [CORDIC_ITERS+1];
  logic signed [XW-1:0] y_r [CORDIC_ITERS+1];
  logic signed [ZW-1:0] z_r [CORDIC_ITERS+1];
  quad_t                k_r [CORDIC_ITERS+1];
  logic signed [CS_W-1:0] cos_r, sin_r;

  assign a32 = {angle, {(32-ANGLE_WIDTH){1'b0}}};

  always_ff @(posedge clk) begin
    // residual in [-45, 45) deg, quadrant rounded to nearest
    x_r[0] <= XW'(CORDIC_K);
    y_r[0] <= '0;
    z_r[0] <= {{(ZW-30){a32[29]}}, a32[29:0]};
    k_r[0] <= quad_t'(a32[31:30] + {1'b0, a32[29]});
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - $signed({1'b0, atan_val(i)});
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + $signed({1'b0, atan_val(i)});
      end
      k_r[i+1] <= k_r[i];
    end
    case (k_r[CORDIC_ITERS])
      QUAD_0: begin
        cos_r <= CS_W'(x_r[CORDIC_ITERS]);
        sin_r <= CS_W'(y_r[CORDIC_ITERS]);
      end
      QUAD_1: begin
        cos_r <= CS_W'(-y_r[CORDIC_ITERS]);
        sin_r <= CS_W'(x_r[CORDIC_ITERS]);
      end
      QUAD_2: begin
        cos_r <= CS_W'(-x_r[CORDIC_ITERS]);
        sin_r <= CS_W'(-y_r[CORDIC_ITERS]);
      end
      default: begin
        cos_r <= CS_W'(y_r[CORDIC_ITERS]);
        sin_r <= CS_W'(-x_r[CORDIC_ITERS]);
      end
    endcase
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ----- rtl/rbsi_rotate.sv -----
`timescale 1ns / 1ps
module rbsi_rotate import rbsi_pkg::*; #(
  parameter int DW = COORD_WIDTH_DEF + 1
) (
  input  logic                   clk,
  input  logic signed [DW-1:0]   ax,
  input  logic signed [DW-1:0]   ay,
  input  logic signed [DW-1:0]   bx,
  input  logic signed [DW-1:0]   by,
  input  logic signed [CS_W-1:0] c,
  input  logic signed [CS_W-1:0] s,
  output logic signed [DW+2:0]   l1x,
  output logic signed [DW+2:0]   l1y,
  output logic signed [DW+2:0]   l2x,
  output logic signed [DW+2:0]   l2y
);

  localparam int SPL = DW / 2;
  localparam int HW  = DW - SPL;
  localparam int PW  = DW + CS_W + 1;
  localparam int MW  = DW + 2;
  localparam int LW  = DW + 3;

  // products: ax*c ay*s ax*s ay*c bx*c by*s bx*s by*c
  logic signed [DW-1:0]       op_a [8];
  logic signed [CS_W-1:0]     op_b [8];
  logic signed [HW+CS_W-1:0]  ph_r [8];
  logic signed [SPL+CS_W:0]   pl_r [8];
  logic signed [PW-1:0]       sum_c [8];
  logic signed [MW-1:0]       m_r [8];
  logic signed [LW-1:0]       l1x_r, l1y_r, l2x_r, l2y_r;

  always_comb begin
    op_a[0] = ax; op_b[0] = c;
    op_a[1] = ay; op_b[1] = s;
    op_a[2] = ax; op_b[2] = s;
    op_a[3] = ay; op_b[3] = c;
    op_a[4] = bx; op_b[4] = c;
    op_a[5] = by; op_b[5] = s;
    op_a[6] = bx; op_b[6] = s;
    op_a[7] = by; op_b[7] = c;
  end

  // split each product into high signed and low unsigned partials
  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      ph_r[j] <= $signed(op_a[j][DW-1:SPL]) * op_b[j];
      pl_r[j] <= $signed({1'b0, op_a[j][SPL-1:0]}) * op_b[j];
    end
  end

  // recombine, round half up to Q16.16
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      sum_c[j] = (PW'(ph_r[j]) <<< SPL) + PW'(pl_r[j]) + PW'(ROUND30);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) m_r[j] <= MW'(sum_c[j] >>> 30);
    l1x_r <= LW'(m_r[0]) + LW'(m_r[1]);
    l1y_r <= LW'(m_r[3]) - LW'(m_r[2]);
    l2x_r <= LW'(m_r[4]) + LW'(m_r[5]);
    l2y_r <= LW'(m_r[7]) - LW'(m_r[6]);
  end

  assign l1x = l1x_r;
  assign l1y = l1y_r;
  assign l2x = l2x_r;
  assign l2y = l2y_r;

endmodule

// ----- rtl/rbsi_div.sv -----
`timescale 1ns / 1ps
module rbsi_div import rbsi_pkg::*; #(
  parameter int NW = 40
) (
  input  logic                  clk,
  input  logic signed [NW-1:0]  num,
  input  logic signed [NW-1:0]  den,
  output logic signed [T_W-1:0] quot
);

  localparam int RW = NW + 1;
  localparam int QB = QUOT_BITS;

  logic [NW-1:0]        n_abs, d_abs;
  logic [RW-1:0]        r_r   [QB+1];
  logic [NW-1:0]        d_r   [QB+1];
  logic [QB-1:0]        q_r   [QB+1];
  logic                 neg_r [QB+1];
  logic                 sat_r [QB+1];
  logic [RW-1:0]        rs_c  [QB];
  logic                 ge_c  [QB];
  logic [QB:0]          qf;
  logic signed [T_W-1:0] quot_r;

  assign n_abs = num[NW-1] ? NW'(-num) : NW'(num);
  assign d_abs = den[NW-1] ? NW'(-den) : NW'(den);

  // one quotient bit per stage: integer bit first, then 16 fraction bits
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      rs_c[k] = (k == 0) ? r_r[k] : (r_r[k] << 1);
      ge_c[k] = rs_c[k] >= {1'b0, d_r[k]};
    end
  end

  always_comb begin
    qf = {1'b0, q_r[QB]} + (QB+1)'(neg_r[QB] && (r_r[QB] != '0));
    if (sat_r[QB] || (qf > (QB+1)'(T_SAT))) qf = (QB+1)'(T_SAT);
  end

  always_ff @(posedge clk) begin
    r_r[0]   <= {1'b0, n_abs};
    d_r[0]   <= d_abs;
    q_r[0]   <= '0;
    neg_r[0] <= num[NW-1] ^ den[NW-1];
    sat_r[0] <= {1'b0, n_abs} >= {d_abs, 1'b0};
    for (int k = 0; k < QB; k++) begin
      r_r[k+1]   <= ge_c[k] ? (rs_c[k] - {1'b0, d_r[k]}) : rs_c[k];
      q_r[k+1]   <= {q_r[k][QB-2:0], ge_c[k]};
      d_r[k+1]   <= d_r[k];
      neg_r[k+1] <= neg_r[k];
      sat_r[k+1] <= sat_r[k];
    end
    quot_r <= neg_r[QB] ? -T_W'(qf) : T_W'(qf);
  end

  assign quot = quot_r;

endmodule
